// ===== rtl/kwm_pkg.sv =====
// Shared types and constants for the k-way minimum merge.
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int DEF_MAX_TAPES = 16;
    localparam int DEF_KEY_BITS  = 14;
    localparam int ID_W          = 27;
    localparam int CFG_W         = 5;

    typedef enum logic {
        S_IDLE,
        S_INSERT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT,
        OP_CLEAR
    } t_cell_op;

    // flags rippling down the chain from the head cell
    typedef struct packed {
        logic removed;  // the removed tape sits at or before this point
        logic placed;   // the new head sorts at or before this point
    } t_link;

endpackage

// ===== rtl/k_way_min_merge.sv =====
// K-way merge of sorted tapes: sorted chain of tape heads, emits the minimum.
// An item is taken when start is high and busy is low; a dropped item leaves
// busy low. For an item that is used, in the accept cycle the chain drops the
// old head of that tape, if it is still in the chain. In the following
// cycle (busy high) the new head is placed in order and the smallest head is
// registered. Its strobe shows the cycle after, while the next item may
// already be accepted. Results appear for one cycle only and cannot be held
// off. After tapes_in_use tapes have all reported, each refill of the tape
// named in source_tape yields the next record. When all tapes have ended, a
// single done result is given and the fill phase starts over. Items for
// tapes outside the count, or for any tape but the pending one while
// merging, are dropped without result. Writing tapes_in_use restarts the
// fill phase; cfg_ready is low while busy or start is high.
`timescale 1ns / 1ps

module k_way_min_merge
    import kwm_pkg::*;
#(
    parameter int MAX_TAPES = DEF_MAX_TAPES,
    parameter int KEY_BITS  = DEF_KEY_BITS,
    localparam int TAPE_W   = $clog2(MAX_TAPES),
    localparam int CNT_W    = $clog2(MAX_TAPES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [TAPE_W-1:0]   i_tape,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [ID_W-1:0]     i_record_id,
    input  logic                i_tape_ended,
    output logic                o_strobe,
    output logic [KEY_BITS-1:0] o_key_res,
    output logic [ID_W-1:0]     o_record_id_res,
    output logic [TAPE_W-1:0]   o_source_tape,
    output logic                o_done_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [MAX_TAPES-1:0]  r_reported;
    logic                  r_merging;
    logic [TAPE_W-1:0]     r_pend;
    logic [TAPE_W-1:0]     r_req_tape;
    logic [KEY_BITS-1:0]   r_req_key;
    logic [ID_W-1:0]       r_req_id;
    logic                  r_req_ended;
    logic                  r_do_emit;
    logic                  r_strobe;
    logic [KEY_BITS-1:0]   r_out_key;
    logic [ID_W-1:0]       r_out_id;
    logic [TAPE_W-1:0]     r_out_tape;
    logic                  r_out_done;

    t_cell_op              cell_op;
    logic [TAPE_W-1:0]     req_tape;
    logic                  cfg_go;
    logic                  item_ok;
    logic                  item_go;
    logic                  all_rep;
    logic [CNT_W-1:0]      cfg_count;
    logic                  head_new;
    logic                  head_valid;

    t_link                 link [MAX_TAPES+1];
    logic [MAX_TAPES:0]    cell_valid;
    logic [KEY_BITS-1:0]   cell_key  [MAX_TAPES+1];
    logic [ID_W-1:0]       cell_id   [MAX_TAPES+1];
    logic [TAPE_W-1:0]     cell_tape [MAX_TAPES+1];

    // ---------------- request decode ----------------
    assign cfg_go  = i_cfg_valid && o_cfg_ready;
    assign item_ok = (CNT_W'(i_tape) < r_count)
                     && (!r_merging || (i_tape == r_pend));
    assign item_go = start && !busy && item_ok;

    always_comb begin
        all_rep = 1'b1;
        for (int i = 0; i < MAX_TAPES; i++) begin
            if (!(r_reported[i] || (TAPE_W'(i) == i_tape)
                  || (CNT_W'(i) >= r_count))) begin
                all_rep = 1'b0;
            end
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_count = CNT_W'(1);
        end else if (int'(i_cfg_data) > MAX_TAPES) begin
            cfg_count = CNT_W'(MAX_TAPES);
        end else begin
            cfg_count = CNT_W'(i_cfg_data);
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (item_go) n_state = S_INSERT;
            S_INSERT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b0;
        cell_op  = OP_HOLD;
        req_tape = i_tape;
        case (r_state)
            S_IDLE: begin
                if (cfg_go) begin
                    cell_op = OP_CLEAR;
                end else if (item_go) begin
                    cell_op = OP_REMOVE;
                end
            end
            S_INSERT: begin
                busy     = 1'b1;
                req_tape = r_req_tape;
                if (!r_req_ended) begin
                    cell_op = OP_INSERT;
                end
            end
            default: begin
            end
        endcase
    end

    // no config write in a cycle that may take an item
    assign o_cfg_ready = !busy && !start;

    // ---------------- head chain ----------------
    assign link[0]          = '0;
    assign cell_valid[MAX_TAPES] = 1'b0;
    assign cell_key[MAX_TAPES]   = '0;
    assign cell_id[MAX_TAPES]    = '0;
    assign cell_tape[MAX_TAPES]  = '0;

    for (genvar g = 0; g < MAX_TAPES; g++) begin : g_cell
        logic                lv;
        logic [KEY_BITS-1:0] lk;
        logic [ID_W-1:0]     li;
        logic [TAPE_W-1:0]   lt;

        if (g == 0) begin : g_head
            assign lv = 1'b0;
            assign lk = '0;
            assign li = '0;
            assign lt = '0;
        end else begin : g_body
            assign lv = cell_valid[g-1];
            assign lk = cell_key[g-1];
            assign li = cell_id[g-1];
            assign lt = cell_tape[g-1];
        end

        kwm_cell #(
            .KEY_BITS (KEY_BITS),
            .TAPE_W   (TAPE_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (cell_op),
            .i_req_tape    (req_tape),
            .i_req_key     (r_req_key),
            .i_req_id      (r_req_id),
            .i_link        (link[g]),
            .o_link        (link[g+1]),
            .i_left_valid  (lv),
            .i_left_key    (lk),
            .i_left_id     (li),
            .i_left_tape   (lt),
            .i_right_valid (cell_valid[g+1]),
            .i_right_key   (cell_key[g+1]),
            .i_right_id    (cell_id[g+1]),
            .i_right_tape  (cell_tape[g+1]),
            .o_valid       (cell_valid[g]),
            .o_key         (cell_key[g]),
            .o_id          (cell_id[g]),
            .o_tape        (cell_tape[g])
        );
    end

    // head of the chain as it will be after this insert
    assign head_new   = !r_req_ended && link[1].placed;
    assign head_valid = head_new || cell_valid[0];

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= CNT_W'(1);
            r_reported <= '0;
            r_merging  <= 1'b0;
            r_pend     <= '0;
            r_do_emit  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_INSERT) && r_do_emit;
            if (cfg_go) begin
                r_count    <= cfg_count;
                r_reported <= '0;
                r_merging  <= 1'b0;
                r_pend     <= '0;
            end else if (item_go) begin
                r_do_emit <= r_merging || all_rep;
                if (!r_merging) begin
                    r_reported[i_tape] <= 1'b1;
                end
            end else if ((r_state == S_INSERT) && r_do_emit) begin
                if (head_valid) begin
                    r_merging <= 1'b1;
                    r_pend    <= head_new ? r_req_tape : cell_tape[0];
                end else begin
                    // all tapes ended: back to fill
                    r_merging  <= 1'b0;
                    r_reported <= '0;
                    r_pend     <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_go) begin
            r_req_tape  <= i_tape;
            r_req_key   <= i_key;
            r_req_id    <= i_record_id;
            r_req_ended <= i_tape_ended;
        end
        if (r_state == S_INSERT) begin
            r_out_done <= !head_valid;
            if (!head_valid) begin
                r_out_key  <= '0;
                r_out_id   <= '0;
                r_out_tape <= '0;
            end else if (head_new) begin
                r_out_key  <= r_req_key;
                r_out_id   <= r_req_id;
                r_out_tape <= r_req_tape;
            end else begin
                r_out_key  <= cell_key[0];
                r_out_id   <= cell_id[0];
                r_out_tape <= cell_tape[0];
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_key_res       = r_out_key;
    assign o_record_id_res = r_out_id;
    assign o_source_tape   = r_out_tape;
    assign o_done_res      = r_out_done;

    // ---------------- assertions ----------------
    a_insert_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INSERT |=> r_state == S_IDLE)
        else $error("insert phase lasted more than one cycle");

    a_record_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_out_done |-> r_merging && (r_pend == r_out_tape)
                                    && cell_valid[0] && (cell_tape[0] == r_out_tape))
        else $error("emitted record does not match pending chain head");

    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_out_done |-> !r_merging && (r_reported == '0) && !cell_valid[0])
        else $error("done result without fill restart");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cell_valid[0] |-> (cell_valid == '0))
        else $error("live head behind an empty cell");

endmodule

// ===== rtl/kwm_cell.sv =====
// One cell of the sorted head chain: holds one live tape head.
`timescale 1ns / 1ps

module kwm_cell
    import kwm_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int TAPE_W   = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_op            i_op,
    input  logic [TAPE_W-1:0]   i_req_tape,
    input  logic [KEY_BITS-1:0] i_req_key,
    input  logic [ID_W-1:0]     i_req_id,
    input  t_link               i_link,
    output t_link               o_link,
    input  logic                i_left_valid,
    input  logic [KEY_BITS-1:0] i_left_key,
    input  logic [ID_W-1:0]     i_left_id,
    input  logic [TAPE_W-1:0]   i_left_tape,
    input  logic                i_right_valid,
    input  logic [KEY_BITS-1:0] i_right_key,
    input  logic [ID_W-1:0]     i_right_id,
    input  logic [TAPE_W-1:0]   i_right_tape,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [ID_W-1:0]     o_id,
    output logic [TAPE_W-1:0]   o_tape
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [ID_W-1:0]     r_id;
    logic [TAPE_W-1:0]   r_tape;

    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [ID_W-1:0]     n_id;
    logic [TAPE_W-1:0]   n_tape;

    logic match;
    logic new_first;

    assign match     = r_valid && (r_tape == i_req_tape);
    // ties on key go to the lower tape
    assign new_first = !r_valid || (i_req_key < r_key)
                       || ((i_req_key == r_key) && (i_req_tape < r_tape));

    assign o_link.removed = i_link.removed | match;
    assign o_link.placed  = i_link.placed | new_first;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_id    = r_id;
        n_tape  = r_tape;
        case (i_op)
            OP_HOLD: begin
            end
            OP_REMOVE: begin
                if (o_link.removed) begin
                    n_valid = i_right_valid;
                    n_key   = i_right_key;
                    n_id    = i_right_id;
                    n_tape  = i_right_tape;
                end
            end
            OP_INSERT: begin
                if (i_link.placed) begin
                    n_valid = i_left_valid;
                    n_key   = i_left_key;
                    n_id    = i_left_id;
                    n_tape  = i_left_tape;
                end else if (new_first) begin
                    n_valid = 1'b1;
                    n_key   = i_req_key;
                    n_id    = i_req_id;
                    n_tape  = i_req_tape;
                end
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_id   <= n_id;
        r_tape <= n_tape;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_id    = r_id;
    assign o_tape  = r_tape;

endmodule

// ===== bench/kwm_merge_checker.sv =====
// Checker for the k-way minimum merge: predicts each result and compares it.
`timescale 1ns / 1ps

module kwm_merge_checker
    import kwm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [$clog2(DEF_MAX_TAPES)-1:0] i_tape,
    input  logic [DEF_KEY_BITS-1:0]      i_key,
    input  logic [ID_W-1:0]              i_record_id,
    input  logic                         i_tape_ended,
    input  logic                         i_strobe,
    input  logic [DEF_KEY_BITS-1:0]      i_key_res,
    input  logic [ID_W-1:0]              i_record_id_res,
    input  logic [$clog2(DEF_MAX_TAPES)-1:0] i_source_tape,
    input  logic                         i_done_res,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [CFG_W-1:0]             i_cfg_data,
    output int                           o_fail_count,
    output int                           o_waiting
);

    localparam int NT = DEF_MAX_TAPES;
    localparam int TW = $clog2(NT);
    localparam int KW = DEF_KEY_BITS;

    typedef struct packed {
        logic [KW-1:0]   key;
        logic [ID_W-1:0] id;
        logic [TW-1:0]   tape;
        logic            done;
    } t_merge_res;

    t_merge_res      due_q[$];
    logic [KW-1:0]   head_key [NT];
    logic [ID_W-1:0] head_id  [NT];
    logic [NT-1:0]   head_live;
    logic [NT-1:0]   reported;
    logic            merging;
    logic [TW-1:0]   pend_tape;
    logic [CFG_W-1:0] tape_cnt;
    int              fails = 0;

    function automatic int used_tapes();
        if (tape_cnt == '0) return 1;
        if (int'(tape_cnt) > NT) return NT;
        return int'(tape_cnt);
    endfunction

    function automatic void restart_merge();
        head_live = '0;
        reported  = '0;
        merging   = 1'b0;
        pend_tape = '0;
    endfunction

    // smallest live head, lowest tape on equal keys; none left means done
    function automatic t_merge_res take_min();
        t_merge_res r;
        int best;
        bit found;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < used_tapes(); i++) begin
            if (head_live[i] && (!found || head_key[i] < head_key[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        r = '0;
        if (!found) begin
            r.done = 1'b1;
            restart_merge();
        end else begin
            pend_tape = TW'(best);
            r.key     = head_key[best];
            r.id      = head_id[best];
            r.tape    = TW'(best);
        end
        return r;
    endfunction

    function automatic bit merge_step(input logic [TW-1:0] t, input logic [KW-1:0] k,
                                      input logic [ID_W-1:0] id, input logic e,
                                      output t_merge_res r);
        int n;
        n = used_tapes();
        r = '0;
        if (int'(t) >= n) return 1'b0;
        if (merging && t != pend_tape) return 1'b0;
        if (e) begin
            head_live[t] = 1'b0;
        end else begin
            head_key[t]  = k;
            head_id[t]   = id;
            head_live[t] = 1'b1;
        end
        if (!merging) begin
            reported[t] = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (!reported[i]) return 1'b0;
            end
            merging = 1'b1;
        end
        r = take_min();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_merge_res r;
        t_merge_res want;
        t_merge_res got;
        string      exp_s;
        string      act_s;
        if (!i_rst_n) begin
            tape_cnt = CFG_W'(1);
            restart_merge();
            due_q.delete();
        end else begin
            // result leaving at this edge belongs to an earlier request
            if (i_strobe) begin
                got = {i_key_res, i_record_id_res, i_source_tape, i_done_res};
                if (due_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: key=%0d id=%0d tape=%0d done=%0b",
                             $time, got.key, got.id, got.tape, got.done);
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        exp_s = $sformatf("key=%0d id=%0d tape=%0d done=%0b",
                                          want.key, want.id, want.tape, want.done);
                        act_s = $sformatf("key=%0d id=%0d tape=%0d done=%0b",
                                          got.key, got.id, got.tape, got.done);
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, exp_s, act_s);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                tape_cnt = i_cfg_data;
                restart_merge();
            end
            if (i_start && !i_busy) begin
                if (merge_step(i_tape, i_key, i_record_id, i_tape_ended, r))
                    due_q.insert(due_q.size(), r);
            end
        end
        o_waiting    <= due_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_k_way_min_merge.sv =====
// Testbench top for the k-way minimum merge: reset, request stimulus, verdict.
`timescale 1ns / 1ps

module tb_k_way_min_merge;
    import kwm_pkg::*;

    localparam int NT          = DEF_MAX_TAPES;
    localparam int TW          = $clog2(NT);
    localparam int KW          = DEF_KEY_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 480;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [TW-1:0]   tape;
    logic [KW-1:0]   key;
    logic [ID_W-1:0] rec_id;
    logic            ended;
    logic            o_strobe;
    logic [KW-1:0]   o_key_res;
    logic [ID_W-1:0] o_record_id_res;
    logic [TW-1:0]   o_source_tape;
    logic            o_done_res;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int chk_fails;
    int chk_waiting;

    int       cycles = 0;
    int       items_sent = 0;
    int       n_results = 0;
    int       want_results = 0;
    logic [TW-1:0] last_tape = '0;
    logic     last_done = 1'b0;
    bit       paced;
    int       cur_count = 1;
    int       runs_left [NT];
    int       run_key [NT];
    bit       tie_keys;

    k_way_min_merge u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_tape         (tape),
        .i_key          (key),
        .i_record_id    (rec_id),
        .i_tape_ended   (ended),
        .o_strobe       (o_strobe),
        .o_key_res      (o_key_res),
        .o_record_id_res(o_record_id_res),
        .o_source_tape  (o_source_tape),
        .o_done_res     (o_done_res),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    kwm_merge_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_tape         (tape),
        .i_key          (key),
        .i_record_id    (rec_id),
        .i_tape_ended   (ended),
        .i_strobe       (o_strobe),
        .i_key_res      (o_key_res),
        .i_record_id_res(o_record_id_res),
        .i_source_tape  (o_source_tape),
        .i_done_res     (o_done_res),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (chk_fails),
        .o_waiting      (chk_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("k_way_min_merge test failed");
            $finish;
        end
    end

    // stimulus follows the tape the block asks to be refilled
    always @(posedge i_clk) begin
        if (o_strobe) begin
            n_results <= n_results + 1;
            last_tape <= o_source_tape;
            last_done <= o_done_res;
        end
    end

    task automatic push_request(input int t, input int k, input logic [ID_W-1:0] id,
                                input bit e);
        int gap;
        gap = paced ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            if (start) start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tape   <= t[TW-1:0];
        key    <= k[KW-1:0];
        rec_id <= id;
        ended  <= e;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic await_result();
        if (start) start <= 1'b0;
        want_results++;
        while (n_results < want_results) @(posedge i_clk);
    endtask

    task automatic req(input int t, input int k, input logic [ID_W-1:0] id, input bit e,
                       input bit gives);
        push_request(t, k, id, e);
        if (gives) await_result();
    endtask

    task automatic write_count(input int v);
        if (start) start <= 1'b0;
        while (chk_waiting != 0) @(posedge i_clk);
        // requests that gave no result may still be going into the chain
        repeat (4) @(posedge i_clk);
        cfg_data  <= v[CFG_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cur_count = v;
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom);
    endfunction

    // runs stay ascending; now and then a key past the grade range
    function automatic int next_key(input int t);
        int k;
        if ($urandom_range(0, 39) == 0) return $urandom_range(10000, 16383);
        k = run_key[t] + (tie_keys ? $urandom_range(0, 1) : $urandom_range(0, 2500));
        if (k > 9999) k = 9999;
        run_key[t] = k;
        return k;
    endfunction

    task automatic feed_tape(input int t);
        if (runs_left[t] > 0) begin
            runs_left[t]--;
            push_request(t, next_key(t), rand_id(), 1'b0);
        end else begin
            push_request(t, $urandom_range(0, 16383), rand_id(), 1'b1);
        end
    endtask

    task automatic noise_request(input int t);
        push_request(t, $urandom_range(0, 16383), rand_id(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_merge(input bit abortable, output bit aborted);
        int n;
        int abort_at;
        int t;
        int j;
        int swap;
        int order [NT];
        n = (cur_count == 0) ? 1 : (cur_count > NT) ? NT : cur_count;
        aborted  = 1'b0;
        tie_keys = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < NT; i++) begin
            order[i]     = i;
            runs_left[i] = ($urandom_range(0, 3) == 0) ? 0 :
                           $urandom_range(1, (n <= 4) ? 8 : 3);
            run_key[i]   = tie_keys ? $urandom_range(0, 2) : $urandom_range(0, 3000);
        end
        for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        abort_at = (abortable && $urandom_range(0, 7) == 0) ? $urandom_range(1, n) : -1;

        for (int p = 0; p < n; p++) begin
            if (p == abort_at) begin
                aborted = 1'b1;
                return;
            end
            if ($urandom_range(0, 5) == 0) begin
                if (p > 0 && $urandom_range(0, 1) == 1)
                    noise_request(order[$urandom_range(0, p - 1)]);  // repeat report
                else if (n < NT)
                    noise_request($urandom_range(n, NT - 1));        // tape not in use
            end
            feed_tape(order[p]);
            if (p == n - 1) await_result();
        end

        while (last_done !== 1'b1) begin
            t = int'(last_tape);
            if ($urandom_range(0, 7) == 0)
                noise_request((t + $urandom_range(1, NT - 1)) % NT);  // wrong refill
            feed_tape(t);
            await_result();
        end
    endtask

    initial begin
        bit aborted;
        int r;
        int v;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        tape      = '0;
        key       = '0;
        rec_id    = '0;
        ended     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        paced     = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count after reset is one tape
        req(1, 77, 5, 1'b0, 1'b0);
        req(0, 9999, {ID_W{1'b1}}, 1'b0, 1'b1);
        req(0, 16383, '0, 1'b0, 1'b1);
        req(0, 0, '0, 1'b1, 1'b1);
        // zero count behaves as one
        write_count(0);
        req(0, 0, '0, 1'b0, 1'b1);
        req(0, 16383, {ID_W{1'b1}}, 1'b1, 1'b1);
        // repeat report, tie on key, wrong refill
        write_count(2);
        req(1, 40, 11, 1'b0, 1'b0);
        req(1, 30, 12, 1'b0, 1'b0);
        req(0, 30, 13, 1'b0, 1'b1);
        req(1, 1, 1, 1'b0, 1'b0);
        req(0, 50, 14, 1'b0, 1'b1);
        req(1, 0, 0, 1'b1, 1'b1);
        req(0, 0, 0, 1'b1, 1'b1);
        // every tape ends during fill
        req(0, 0, 0, 1'b1, 1'b0);
        req(1, 0, 0, 1'b1, 1'b1);
        // count write in the middle of a fill
        req(1, 100, 1, 1'b0, 1'b0);
        write_count(31);
        aborted = 1'b1;

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 15);
            case (r)
                0: v = 0;
                1: v = 31;
                2: v = 16;
                3: v = $urandom_range(17, 30);
                default: v = $urandom_range(1, 5);
            endcase
            if (aborted || $urandom_range(0, 2) != 0) write_count(v);
            paced = ($urandom_range(0, 3) != 0);
            run_merge(1'b1, aborted);
        end

        if (start) start <= 1'b0;
        while (chk_waiting != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (chk_fails == 0 && chk_waiting == 0) begin
            $display("k_way_min_merge test passed");
        end else begin
            $display("k_way_min_merge test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kwm_pkg.sv
rtl/kwm_cell.sv
rtl/k_way_min_merge.sv
bench/kwm_merge_checker.sv
bench/tb_k_way_min_merge.sv
